// ----- hdl/b64d_pkg.sv -----
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, constants and the character classifier for the base64url decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  // front/back queue
  localparam int QDEPTH = 2;
  localparam int QIDX_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int CNT_W = 17;
  localparam logic [CNT_W-1:0] COUNT_MAX = 17'h1FFFF;

  localparam logic [5:0] LOWER_OFS  = 6'd26;
  localparam logic [5:0] DIGIT_OFS  = 6'd52;
  localparam logic [5:0] DASH_VAL   = 6'd62;
  localparam logic [5:0] USCORE_VAL = 6'd63;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_LEN   = 3'd1,
    ST_TOO_SMALL = 3'd2,
    ST_BAD_CHAR  = 3'd3,
    ST_NONCANON  = 3'd4
  } status_e;

  // classified character as it travels from front to back
  typedef struct packed {
    logic [5:0] sextet;
    logic       bad;
    logic       last;
  } char_cls_t;

  typedef struct packed {
    logic      push;
    char_cls_t entry;
  } q_wr_t;

  typedef struct packed {
    logic      valid;
    char_cls_t entry;
  } q_rd_t;

  // map a raw character to its sextet; outside the alphabet reads as 0, bad
  function automatic char_cls_t classify(input logic [7:0] ch, input logic last);
    char_cls_t r;
    logic [7:0] d;
    r.last   = last;
    r.bad    = 1'b0;
    r.sextet = '0;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      d = ch - 8'h41;
      r.sextet = d[5:0];
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      d = ch - 8'h61;
      r.sextet = d[5:0] + LOWER_OFS;
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      d = ch - 8'h30;
      r.sextet = d[5:0] + DIGIT_OFS;
    end else if (ch == 8'h2D) begin
      r.sextet = DASH_VAL;
    end else if (ch == 8'h5F) begin
      r.sextet = USCORE_VAL;
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

endpackage

// ----- hdl/b64d_if.sv -----
// ----------------------------------------------------------------------------
// b64d_if
// Valid/ready channels of the base64url decoder: input, result, register.
// ----------------------------------------------------------------------------
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface b64d_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        byte_valid;
  logic        end_of_message;
  logic [2:0]  status;
  logic [15:0] decoded_total;

  modport source (output valid, output data_byte, output byte_valid,
                  output end_of_message, output status, output decoded_total,
                  input ready);
  modport sink   (input valid, input data_byte, input byte_valid,
                  input end_of_message, input status, input decoded_total,
                  output ready);
endinterface

interface b64d_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] byte_limit;

  modport source (output valid, output byte_limit, input ready);
  modport sink   (input valid, input byte_limit, output ready);
endinterface

// ----- hdl/b64d_queue.sv -----
// ----------------------------------------------------------------------------
// b64d_queue
// Short FIFO of classified characters between front and back.
// ----------------------------------------------------------------------------
module b64d_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  b64d_pkg::q_wr_t   wr_i,
  output logic              full_o,
  output b64d_pkg::q_rd_t   rd_o,
  input  logic              pop_i
);
  import b64d_pkg::*;

  char_cls_t          mem_q [QDEPTH];
  logic [QIDX_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QIDX_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign do_push = wr_i.push && !full_o;
  assign do_pop  = pop_i && (cnt_q != '0);

  assign rd_o.valid = (cnt_q != '0);
  assign rd_o.entry = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QIDX_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QIDX_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_i.entry;
    end
  end

endmodule

// ----- hdl/b64d_front.sv -----
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, maps them to sextets and pushes them into the queue.
// ----------------------------------------------------------------------------
module b64d_front (
  b64d_in_if.sink          in_i,
  input  logic             full_i,
  output b64d_pkg::q_wr_t  wr_o
);
  import b64d_pkg::*;

  assign in_i.ready = !full_i;
  assign wr_o.push  = in_i.valid && !full_i;
  assign wr_o.entry = classify(in_i.char_code, in_i.last_char);

endmodule

// ----- hdl/b64d_back.sv -----
// ----------------------------------------------------------------------------
// b64d_back
// Group tracking, byte assembly, end-of-message status and the result register.
// ----------------------------------------------------------------------------
module b64d_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  b64d_pkg::q_rd_t  rd_i,
  output logic             pop_o,
  input  logic [15:0]      limit_i,
  b64d_out_if.source       out_o
);
  import b64d_pkg::*;

  logic [1:0]       pos_q, pos_d;
  logic [5:0]       prev_q, prev_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             bad_q, bad_d;

  logic             ovalid_q, ovalid_d;
  logic [7:0]       obyte_q;
  logic             obv_q;
  logic             oeom_q;
  status_e          ostat_q;
  logic [15:0]      otot_q;

  logic             take;
  logic [5:0]       v;
  logic [7:0]       byte_val;
  logic             bv;
  logic [CNT_W-1:0] cnt_inc;
  logic             bad_n;
  logic             emit;
  status_e          stat;
  logic [15:0]      total;

  // next entry moves on when the result register is free or draining
  assign take  = rd_i.valid && (!ovalid_q || out_o.ready);
  assign pop_o = take;
  assign v     = rd_i.entry.sextet;

  always_comb begin
    bv = 1'b1;
    case (pos_q)
      2'd1:    byte_val = {prev_q, v[5:4]};
      2'd2:    byte_val = {prev_q[3:0], v[5:2]};
      2'd3:    byte_val = {prev_q[1:0], v};
      default: begin
        byte_val = '0;
        bv       = 1'b0;
      end
    endcase
  end

  assign cnt_inc = (bv && cnt_q != COUNT_MAX) ? cnt_q + 1'b1 : cnt_q;
  assign bad_n   = bad_q | rd_i.entry.bad;
  assign emit    = rd_i.entry.last || bv;

  always_comb begin
    stat = ST_OK;
    if (rd_i.entry.last) begin
      if (pos_q == 2'd0) begin
        stat = ST_BAD_LEN;
      end else if (cnt_inc > {1'b0, limit_i}) begin
        stat = ST_TOO_SMALL;
      end else if (bad_n) begin
        stat = ST_BAD_CHAR;
      end else if ((pos_q == 2'd1 && v[3:0] != 4'd0) ||
                   (pos_q == 2'd2 && v[1:0] != 2'd0)) begin
        stat = ST_NONCANON;
      end
    end
  end

  assign total = (rd_i.entry.last && stat == ST_OK) ? cnt_inc[15:0] : 16'd0;

  always_comb begin
    pos_d    = pos_q;
    prev_d   = prev_q;
    cnt_d    = cnt_q;
    bad_d    = bad_q;
    ovalid_d = ovalid_q;
    if (take) begin
      ovalid_d = emit;
      if (rd_i.entry.last) begin
        pos_d  = '0;
        prev_d = '0;
        cnt_d  = '0;
        bad_d  = 1'b0;
      end else begin
        pos_d  = pos_q + 2'd1;
        prev_d = v;
        cnt_d  = cnt_inc;
        bad_d  = bad_n;
      end
    end else if (out_o.ready) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      prev_q   <= '0;
      cnt_q    <= '0;
      bad_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      prev_q   <= prev_d;
      cnt_q    <= cnt_d;
      bad_q    <= bad_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      obyte_q <= byte_val;
      obv_q   <= bv;
      oeom_q  <= rd_i.entry.last;
      ostat_q <= stat;
      otot_q  <= total;
    end
  end

  assign out_o.valid          = ovalid_q;
  assign out_o.data_byte      = obyte_q;
  assign out_o.byte_valid     = obv_q;
  assign out_o.end_of_message = oeom_q;
  assign out_o.status         = ostat_q;
  assign out_o.decoded_total  = otot_q;

endmodule

// ----- hdl/base64url_decoder_no_padding.sv -----
// ----------------------------------------------------------------------------
// base64url_decoder_no_padding
// Streaming base64url decoder, no padding, one character per word.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                   accepted when
//  in_i     in   char_code, last_char                      valid && ready
//  out_o    out  data_byte, byte_valid, end_of_message,    valid && ready
//                status, decoded_total
//  cfg_i    in   byte_limit                                valid && ready
//
//  One character per cycle sustained while out_o does not stall. An accepted
//  word is written into the two-entry front/back queue and is decoded on its
//  way from there into the result register. The queue full flag alone sets
//  in_i.ready; out_o stalls back up through the result register into the
//  queue.
//  Reset clears group state and loads byte_limit with 65535. cfg_i is always
//  ready.
// ----------------------------------------------------------------------------
module base64url_decoder_no_padding (
  input  logic        clk_i,
  input  logic        rst_ni,
  b64d_in_if.sink     in_i,
  b64d_out_if.source  out_o,
  b64d_cfg_if.sink    cfg_i
);
  import b64d_pkg::*;

  q_wr_t       q_wr;
  q_rd_t       q_rd;
  logic        q_full;
  logic        q_pop;
  logic [15:0] limit_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 16'hFFFF;
    end else if (cfg_i.valid) begin
      limit_q <= cfg_i.byte_limit;
    end
  end

  b64d_front u_front (
    .in_i   (in_i),
    .full_i (q_full),
    .wr_o   (q_wr)
  );

  b64d_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (q_wr),
    .full_o (q_full),
    .rd_o   (q_rd),
    .pop_i  (q_pop)
  );

  b64d_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_i    (q_rd),
    .pop_o   (q_pop),
    .limit_i (limit_q),
    .out_o   (out_o)
  );

  // mid-group results always carry a byte and no end status
  a_mid_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.end_of_message |->
      out_o.byte_valid && out_o.status == ST_OK && out_o.decoded_total == 16'd0)
    else $error("mid-message result without byte or with status");

  // a word without a byte can only be an end with zero data
  a_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.byte_valid |->
      out_o.end_of_message && out_o.data_byte == 8'd0)
    else $error("byteless result that is not an end of message");

  // a clean end has decoded at least one byte
  a_ok_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.end_of_message && out_o.status == ST_OK |->
      out_o.decoded_total != 16'd0 && out_o.byte_valid)
    else $error("ok end of message with zero total");

endmodule
